>>> rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DRAE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define DRAE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/drae_pkg.sv
// types and constants of the dns answer extractor
package drae_pkg;

  localparam int unsigned MaxMessageBytes = 512;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QFIX   = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFIX   = 4'd8,
    PH_RDATA  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_NXDOMAIN = 2'd2,
    ST_NOANSWER = 2'd3
  } status_e;

  localparam logic [7:0]  PtrMask   = 8'hC0;
  localparam logic [15:0] RcodeMask = 16'h000F;
  localparam logic [15:0] RcodeNx   = 16'd3;
  localparam int unsigned HeaderBytes = 12;
  localparam logic [15:0] TypeA     = 16'd1;
  localparam logic [15:0] TypeAaaa  = 16'd28;
  localparam logic [15:0] ClassIn   = 16'd1;
  localparam logic [15:0] LenA      = 16'd4;
  localparam logic [15:0] LenAaaa   = 16'd16;
  localparam logic [3:0]  QfixLast  = 4'd3;

  typedef struct packed {
    status_e     status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] ttl;
  } result_t;

endpackage

>>> rtl/drae_parser.sv
// per-byte parse state and decision logic of the dns answer extractor
`include "assert_macros.svh"

module drae_parser #(
  parameter int unsigned MaxMessageBytes = drae_pkg::MaxMessageBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [15:0]       expected_id_i,
  input  logic              want_ipv6_i,
  output logic              emit_o,
  output drae_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(MaxMessageBytes + 1);

  // header byte positions
  localparam logic [CntW-1:0] HdrIdHi    = CntW'(0);
  localparam logic [CntW-1:0] HdrIdLo    = CntW'(1);
  localparam logic [CntW-1:0] HdrFlagsHi = CntW'(2);
  localparam logic [CntW-1:0] HdrFlagsLo = CntW'(3);
  localparam logic [CntW-1:0] HdrQdHi    = CntW'(4);
  localparam logic [CntW-1:0] HdrQdLo    = CntW'(5);
  localparam logic [CntW-1:0] HdrAnHi    = CntW'(6);
  localparam logic [CntW-1:0] HdrAnLo    = CntW'(7);
  localparam logic [CntW-1:0] HdrLast    = CntW'(drae_pkg::HeaderBytes - 1);

  // answer fixed-field positions
  localparam logic [3:0] FixTypeHi  = 4'd0;
  localparam logic [3:0] FixTypeLo  = 4'd1;
  localparam logic [3:0] FixClassHi = 4'd2;
  localparam logic [3:0] FixClassLo = 4'd3;
  localparam logic [3:0] FixTtl0    = 4'd4;
  localparam logic [3:0] FixTtl1    = 4'd5;
  localparam logic [3:0] FixTtl2    = 4'd6;
  localparam logic [3:0] FixTtl3    = 4'd7;
  localparam logic [3:0] FixLenHi   = 4'd8;

  drae_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      flags_q, flags_d;
  logic [15:0]      qleft_q, qleft_d;
  logic [15:0]      aleft_q, aleft_d;
  logic [7:0]       label_q, label_d;
  logic [3:0]       ffi_q, ffi_d;
  logic [15:0]      rtype_q, rtype_d;
  logic [15:0]      rclass_q, rclass_d;
  logic [31:0]      rttl_q, rttl_d;
  logic [15:0]      rdata_q, rdata_d;
  logic [63:0]      shift_hi_q, shift_hi_d;
  logic [63:0]      shift_lo_q, shift_lo_d;
  logic             decided_q, decided_d;

  logic             emit;
  logic             do_next;
  logic             active;
  logic [15:0]      want_type;
  logic [15:0]      want_len;
  logic [15:0]      rdata_full;

  assign active     = cnt_q < CntW'(MaxMessageBytes);
  assign want_type  = want_ipv6_i ? drae_pkg::TypeAaaa : drae_pkg::TypeA;
  assign want_len   = want_ipv6_i ? drae_pkg::LenAaaa : drae_pkg::LenA;
  assign rdata_full = rdata_q | {8'h00, data_byte_i};

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    flags_d    = flags_q;
    qleft_d    = qleft_q;
    aleft_d    = aleft_q;
    label_d    = label_q;
    ffi_d      = ffi_q;
    rtype_d    = rtype_q;
    rclass_d   = rclass_q;
    rttl_d     = rttl_q;
    rdata_d    = rdata_q;
    shift_hi_d = shift_hi_q;
    shift_lo_d = shift_lo_q;
    decided_d  = decided_q;
    emit       = 1'b0;
    do_next    = 1'b0;
    result_o   = '0;

    if (accept_i) begin
      if (active) begin
        cnt_d = cnt_q + CntW'(1);
        if (!decided_q) begin
          unique case (phase_q)
            drae_pkg::PH_HEADER: begin
              unique case (cnt_q)
                HdrIdHi:    flags_d = {data_byte_i, 8'h00};
                HdrIdLo: begin
                  if ((flags_q | {8'h00, data_byte_i}) != expected_id_i) begin
                    emit            = 1'b1;
                    result_o.status = drae_pkg::ST_FORMAT;
                  end
                end
                HdrFlagsHi: flags_d = {data_byte_i, 8'h00};
                HdrFlagsLo: flags_d = flags_q | {8'h00, data_byte_i};
                HdrQdHi:    qleft_d = {data_byte_i, 8'h00};
                HdrQdLo:    qleft_d = qleft_q | {8'h00, data_byte_i};
                HdrAnHi:    aleft_d = {data_byte_i, 8'h00};
                HdrAnLo:    aleft_d = aleft_q | {8'h00, data_byte_i};
                HdrLast: begin
                  if ((flags_q & drae_pkg::RcodeMask) == drae_pkg::RcodeNx) begin
                    emit            = 1'b1;
                    result_o.status = drae_pkg::ST_NXDOMAIN;
                  end else begin
                    do_next = 1'b1;
                  end
                end
                default: ;
              endcase
            end
            drae_pkg::PH_QNAME, drae_pkg::PH_ANAME: begin
              if (data_byte_i == 8'h00) begin
                phase_d = (phase_q == drae_pkg::PH_QNAME) ? drae_pkg::PH_QFIX
                                                          : drae_pkg::PH_AFIX;
                ffi_d   = '0;
              end else if ((data_byte_i & drae_pkg::PtrMask) == drae_pkg::PtrMask) begin
                phase_d = (phase_q == drae_pkg::PH_QNAME) ? drae_pkg::PH_QPTR
                                                          : drae_pkg::PH_APTR;
              end else begin
                label_d = data_byte_i;
                phase_d = (phase_q == drae_pkg::PH_QNAME) ? drae_pkg::PH_QLABEL
                                                          : drae_pkg::PH_ALABEL;
              end
            end
            drae_pkg::PH_QLABEL, drae_pkg::PH_ALABEL: begin
              label_d = label_q - 8'd1;
              if (label_d == 8'd0) begin
                phase_d = (phase_q == drae_pkg::PH_QLABEL) ? drae_pkg::PH_QNAME
                                                           : drae_pkg::PH_ANAME;
              end
            end
            drae_pkg::PH_QPTR: begin
              phase_d = drae_pkg::PH_QFIX;
              ffi_d   = '0;
            end
            drae_pkg::PH_APTR: begin
              phase_d = drae_pkg::PH_AFIX;
              ffi_d   = '0;
            end
            drae_pkg::PH_QFIX: begin
              if (ffi_q < drae_pkg::QfixLast) begin
                ffi_d = ffi_q + 4'd1;
              end else begin
                qleft_d = qleft_q - 16'd1;
                do_next = 1'b1;
              end
            end
            drae_pkg::PH_AFIX: begin
              ffi_d = ffi_q + 4'd1;
              unique case (ffi_q)
                FixTypeHi:  rtype_d  = {data_byte_i, 8'h00};
                FixTypeLo:  rtype_d  = rtype_q | {8'h00, data_byte_i};
                FixClassHi: rclass_d = {data_byte_i, 8'h00};
                FixClassLo: rclass_d = rclass_q | {8'h00, data_byte_i};
                FixTtl0, FixTtl1, FixTtl2, FixTtl3:
                  rttl_d = {rttl_q[23:0], data_byte_i};
                FixLenHi:   rdata_d  = {data_byte_i, 8'h00};
                default: begin
                  ffi_d      = ffi_q;
                  rdata_d    = rdata_full;
                  // a cleared class marks the record as not wanted
                  if (rtype_q != want_type || rclass_q != drae_pkg::ClassIn ||
                      rdata_full != want_len) begin
                    rclass_d = '0;
                  end
                  aleft_d    = aleft_q - 16'd1;
                  shift_hi_d = '0;
                  shift_lo_d = '0;
                  if (rdata_full == 16'd0) begin
                    do_next = 1'b1;
                  end else begin
                    phase_d = drae_pkg::PH_RDATA;
                  end
                end
              endcase
            end
            drae_pkg::PH_RDATA: begin
              shift_hi_d = {shift_hi_q[55:0], shift_lo_q[63:56]};
              shift_lo_d = {shift_lo_q[55:0], data_byte_i};
              rdata_d    = rdata_q - 16'd1;
              if (rdata_d == 16'd0) begin
                if (rclass_q == drae_pkg::ClassIn) begin
                  emit               = 1'b1;
                  result_o.status    = drae_pkg::ST_OK;
                  result_o.addr_high = shift_hi_d;
                  result_o.addr_low  = shift_lo_d;
                  result_o.ttl       = rttl_q;
                end else begin
                  do_next = 1'b1;
                end
              end
            end
            default: ;
          endcase

          // move on to the next question or answer, or give up
          if (do_next) begin
            if (qleft_d != 16'd0) begin
              phase_d = drae_pkg::PH_QNAME;
            end else if (aleft_d != 16'd0) begin
              phase_d = drae_pkg::PH_ANAME;
            end else begin
              emit            = 1'b1;
              result_o.status = drae_pkg::ST_NOANSWER;
            end
          end
        end
      end

      if (emit) begin
        decided_d = 1'b1;
      end

      // end of message: flag a cut-off and start afresh
      if (last_byte_i) begin
        if (!decided_q && !emit) begin
          emit            = 1'b1;
          result_o.status = drae_pkg::ST_FORMAT;
        end
        phase_d    = drae_pkg::PH_HEADER;
        cnt_d      = '0;
        flags_d    = '0;
        qleft_d    = '0;
        aleft_d    = '0;
        label_d    = '0;
        ffi_d      = '0;
        rtype_d    = '0;
        rclass_d   = '0;
        rttl_d     = '0;
        rdata_d    = '0;
        shift_hi_d = '0;
        shift_lo_d = '0;
        decided_d  = 1'b0;
      end
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= drae_pkg::PH_HEADER;
      cnt_q      <= '0;
      flags_q    <= '0;
      qleft_q    <= '0;
      aleft_q    <= '0;
      label_q    <= '0;
      ffi_q      <= '0;
      rtype_q    <= '0;
      rclass_q   <= '0;
      rttl_q     <= '0;
      rdata_q    <= '0;
      shift_hi_q <= '0;
      shift_lo_q <= '0;
      decided_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      flags_q    <= flags_d;
      qleft_q    <= qleft_d;
      aleft_q    <= aleft_d;
      label_q    <= label_d;
      ffi_q      <= ffi_d;
      rtype_q    <= rtype_d;
      rclass_q   <= rclass_d;
      rttl_q     <= rttl_d;
      rdata_q    <= rdata_d;
      shift_hi_q <= shift_hi_d;
      shift_lo_q <= shift_lo_d;
      decided_q  <= decided_d;
    end
  end

  `DRAE_ASSERT(a_cnt_bounded, cnt_q <= CntW'(MaxMessageBytes))
  `DRAE_ASSERT(a_header_in_range,
    (phase_q == drae_pkg::PH_HEADER && !decided_q) |-> (cnt_q <= HdrLast))
  `DRAE_ASSERT(a_decided_after_emit,
    (accept_i && emit && !last_byte_i) |=> decided_q)
  `DRAE_ASSERT_NEVER(a_no_second_result, accept_i && emit && decided_q && !last_byte_i)

endmodule

>>> rtl/drae_result_fifo.sv
// two-entry result queue between the parser and the output channel
`include "assert_macros.svh"

module drae_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  drae_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output drae_pkg::result_t out_data_o
);

  drae_pkg::result_t entry_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign full_o      = count_q == 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DRAE_ASSERT(a_count_bounded, count_q <= 2'd2)
  `DRAE_ASSERT_NEVER(a_push_when_full, push_i && full_o)
  `DRAE_ASSERT(a_ptrs_match_count,
    ((count_q == 2'd0) || (count_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))

endmodule

>>> rtl/dns_response_answer_extractor.sv
// One request is one byte of a DNS response; the block takes one request per cycle unless stalled
// and gives one result per message (ok with the first class-IN A or AAAA address and
// its TTL, format error, NXDOMAIN or no answer), written into a two-entry result queue
// when the byte that decides it is taken. Input stalls only while that queue holds two results
// nobody has taken, so throughput is one byte per cycle whenever the output side keeps up.
// Bytes past MaxMessageBytes are dropped but last_byte still closes the message.
module dns_response_answer_extractor #(
  parameter int unsigned MaxMessageBytes = drae_pkg::MaxMessageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] expected_id_i,
  input  logic        want_ipv6_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic [31:0] ttl_seconds_o
);

  logic              accept;
  logic              emit;
  logic              full;
  drae_pkg::result_t result;
  drae_pkg::result_t out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  drae_parser #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .expected_id_i(expected_id_i),
    .want_ipv6_i  (want_ipv6_i),
    .emit_o       (emit),
    .result_o     (result)
  );

  drae_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .push_data_i(result),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign status_o      = out_data.status;
  assign addr_high_o   = out_data.addr_high;
  assign addr_low_o    = out_data.addr_low;
  assign ttl_seconds_o = out_data.ttl;

endmodule
